FILE: design/v3a_pkg.sv
// Shared widths, operation codes, payload types and saturation helper for the vector ALU.
`default_nettype none

package v3a_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int WORD_BITS   = 32;
   localparam int IO_BITS     = 32;
   localparam int V           = (WORD_BITS < 32) ? WORD_BITS : 32;
   localparam int F           = FRAC_BITS;
   localparam int PW          = 2 * V;
   localparam int SW          = 2 * V + 2;
   localparam int QW          = V + F;
   localparam int MW          = (SW > QW) ? SW : QW;
   localparam int RW          = V + 3;
   localparam int SQRT_STAGES = V;
   localparam int DIV_STAGES  = QW;
   localparam int SIDE_DEPTH  = SQRT_STAGES + DIV_STAGES;
   localparam int BACK_LAT    = SIDE_DEPTH + 4;
   localparam int QDEPTH      = 2;
   localparam int QAW         = $clog2(QDEPTH);
   localparam int QCW         = $clog2(QDEPTH + 1);

   localparam logic [MW-1:0] VMAX_M = MW'((64'd1 << (V - 1)) - 64'd1);
   localparam logic [MW-1:0] VMIN_M = VMAX_M + MW'(1);
   localparam logic [V-1:0]  VMAX_V = {1'b0, {(V - 1){1'b1}}};
   localparam logic [V-1:0]  VMIN_V = {1'b1, {(V - 1){1'b0}}};

   typedef enum logic [3:0] {
      MODE_NEG       = 4'd0,
      MODE_ADD       = 4'd1,
      MODE_SUB       = 4'd2,
      MODE_MUL       = 4'd3,
      MODE_SCALE     = 4'd4,
      MODE_DIV       = 4'd5,
      MODE_DIVSCALAR = 4'd6,
      MODE_DOT       = 4'd7,
      MODE_CROSS     = 4'd8,
      MODE_MAGSQ     = 4'd9,
      MODE_MAG       = 4'd10,
      MODE_UNIT      = 4'd11
   } mode_type;

   typedef enum logic [3:0] {
      OP_ZERO, OP_NEG, OP_ADD, OP_SUB, OP_MUL, OP_DIV,
      OP_DOT, OP_CROSS, OP_MAGSQ, OP_MAG, OP_UNIT
   } op_type;

   typedef struct packed {
      logic [3:0]                 mode;
      logic signed [IO_BITS-1:0]  a_x;
      logic signed [IO_BITS-1:0]  a_y;
      logic signed [IO_BITS-1:0]  a_z;
      logic signed [IO_BITS-1:0]  b_x;
      logic signed [IO_BITS-1:0]  b_y;
      logic signed [IO_BITS-1:0]  b_z;
      logic signed [IO_BITS-1:0]  factor;
   } req_type;

   typedef struct packed {
      logic signed [IO_BITS-1:0]  r_x;
      logic signed [IO_BITS-1:0]  r_y;
      logic signed [IO_BITS-1:0]  r_z;
      logic signed [IO_BITS-1:0]  r_scalar;
      logic                       saturated;
      logic                       div_zero;
   } rsp_type;

   typedef struct packed {
      op_type           op;
      logic [2:0][V-1:0] a;
      logic [2:0][V-1:0] b;
   } word_type;

   typedef struct packed {
      logic [V-1:0] val;
      logic         sat;
   } fin_type;

   function automatic fin_type fin(input logic [MW-1:0] mag, input logic neg);
      fin_type f;
      f.sat = 1'b0;
      if (!neg || mag == '0) begin
         if (mag > VMAX_M) begin
            f.sat = 1'b1;
            f.val = VMAX_V;
         end else begin
            f.val = mag[V-1:0];
         end
      end else begin
         if (mag > VMIN_M) begin
            f.sat = 1'b1;
            f.val = VMIN_V;
         end else begin
            f.val = ~mag[V-1:0] + 1'b1;
         end
      end
      return f;
   endfunction

endpackage

`default_nettype wire

FILE: design/v3a_front.sv
// Front end: accept a request word and classify it into an operation for the queue.
`default_nettype none

module v3a_front (
   input  wire v3a_pkg::req_type  req_data,
   input  wire                    start,
   input  wire                    full,
   output logic                   push,
   output v3a_pkg::word_type      word,
   output logic                   busy
);

   v3a_pkg::mode_type mode;

   assign mode = v3a_pkg::mode_type'(req_data.mode);
   assign busy = full;
   assign push = start && !full;

   always_comb begin
      word.a[0] = req_data.a_x[v3a_pkg::V-1:0];
      word.a[1] = req_data.a_y[v3a_pkg::V-1:0];
      word.a[2] = req_data.a_z[v3a_pkg::V-1:0];
      word.b[0] = req_data.b_x[v3a_pkg::V-1:0];
      word.b[1] = req_data.b_y[v3a_pkg::V-1:0];
      word.b[2] = req_data.b_z[v3a_pkg::V-1:0];
      word.op   = v3a_pkg::OP_ZERO;
      unique case (mode)
         v3a_pkg::MODE_NEG:   word.op = v3a_pkg::OP_NEG;
         v3a_pkg::MODE_ADD:   word.op = v3a_pkg::OP_ADD;
         v3a_pkg::MODE_SUB:   word.op = v3a_pkg::OP_SUB;
         v3a_pkg::MODE_MUL:   word.op = v3a_pkg::OP_MUL;
         v3a_pkg::MODE_DIV:   word.op = v3a_pkg::OP_DIV;
         v3a_pkg::MODE_DOT:   word.op = v3a_pkg::OP_DOT;
         v3a_pkg::MODE_CROSS: word.op = v3a_pkg::OP_CROSS;
         v3a_pkg::MODE_MAGSQ: word.op = v3a_pkg::OP_MAGSQ;
         v3a_pkg::MODE_MAG:   word.op = v3a_pkg::OP_MAG;
         v3a_pkg::MODE_UNIT:  word.op = v3a_pkg::OP_UNIT;
         v3a_pkg::MODE_SCALE, v3a_pkg::MODE_DIVSCALAR: begin
            word.op = (mode == v3a_pkg::MODE_SCALE) ? v3a_pkg::OP_MUL : v3a_pkg::OP_DIV;
            for (int i = 0; i < 3; i++) begin
               word.b[i] = req_data.factor[v3a_pkg::V-1:0];
            end
         end
         default: word.op = v3a_pkg::OP_ZERO;
      endcase
   end

endmodule

`default_nettype wire

FILE: design/v3a_queue.sv
// Short queue between the front end and the execution back end.
`default_nettype none

module v3a_queue (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      push,
   input  wire v3a_pkg::word_type   word_in,
   input  wire                      pop,
   output logic                     valid,
   output logic                     full,
   output v3a_pkg::word_type        word_out
);

   v3a_pkg::word_type         mem_ff [v3a_pkg::QDEPTH];
   logic [v3a_pkg::QAW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [v3a_pkg::QCW-1:0]   count_ff, count_in;
   logic                      do_pop;

   assign valid    = count_ff != '0;
   assign full     = count_ff == v3a_pkg::QCW'(v3a_pkg::QDEPTH);
   assign word_out = mem_ff[rd_ff];
   assign do_pop   = pop && valid;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == v3a_pkg::QAW'(v3a_pkg::QDEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == v3a_pkg::QAW'(v3a_pkg::QDEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      priority if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= word_in;
      end
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue written while full");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= v3a_pkg::QCW'(v3a_pkg::QDEPTH))
      else $error("queue count out of range");
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !push) |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue count missed a pop");

endmodule

`default_nettype wire

FILE: design/v3a_sqrt.sv
// Pipelined integer square root, two radicand bits per stage.
`default_nettype none

module v3a_sqrt (
   input  wire                     clock,
   input  wire [v3a_pkg::PW-1:0]   rad,
   output logic [v3a_pkg::V-1:0]   root
);

   typedef struct packed {
      logic [v3a_pkg::PW-1:0] rad;
      logic [v3a_pkg::RW-1:0] rem;
      logic [v3a_pkg::V-1:0]  root;
   } sq_stage_type;

   sq_stage_type            st_ff [v3a_pkg::SQRT_STAGES];
   sq_stage_type            st_in [v3a_pkg::SQRT_STAGES];
   sq_stage_type            src   [v3a_pkg::SQRT_STAGES];
   logic [v3a_pkg::RW-1:0]  rem2  [v3a_pkg::SQRT_STAGES];
   logic [v3a_pkg::RW-1:0]  trial [v3a_pkg::SQRT_STAGES];

   assign root = st_ff[v3a_pkg::SQRT_STAGES-1].root;

   always_comb begin
      for (int k = 0; k < v3a_pkg::SQRT_STAGES; k++) begin
         if (k == 0) begin
            src[k].rad  = rad;
            src[k].rem  = '0;
            src[k].root = '0;
         end else begin
            src[k] = st_ff[k-1];
         end
         rem2[k]  = {src[k].rem[v3a_pkg::RW-3:0], src[k].rad[v3a_pkg::PW-1 -: 2]};
         trial[k] = v3a_pkg::RW'({src[k].root, 2'b01});
         st_in[k].rad = src[k].rad << 2;
         if (rem2[k] >= trial[k]) begin
            st_in[k].rem  = rem2[k] - trial[k];
            st_in[k].root = {src[k].root[v3a_pkg::V-2:0], 1'b1};
         end else begin
            st_in[k].rem  = rem2[k];
            st_in[k].root = {src[k].root[v3a_pkg::V-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      st_ff <= st_in;
   end

endmodule

`default_nettype wire

FILE: design/v3a_div.sv
// Pipelined restoring divider for one lane, one quotient bit per stage.
`default_nettype none

module v3a_div (
   input  wire                     clock,
   input  wire [v3a_pkg::QW-1:0]   dividend,
   input  wire [v3a_pkg::V-1:0]    divisor,
   output logic [v3a_pkg::QW-1:0]  quot
);

   typedef struct packed {
      logic [v3a_pkg::QW-1:0] nq;
      logic [v3a_pkg::V-1:0]  rem;
      logic [v3a_pkg::V-1:0]  den;
   } dv_stage_type;

   dv_stage_type            st_ff [v3a_pkg::DIV_STAGES];
   dv_stage_type            st_in [v3a_pkg::DIV_STAGES];
   dv_stage_type            src   [v3a_pkg::DIV_STAGES];
   logic [v3a_pkg::V:0]     rem2  [v3a_pkg::DIV_STAGES];
   logic [v3a_pkg::V:0]     diff  [v3a_pkg::DIV_STAGES];

   assign quot = st_ff[v3a_pkg::DIV_STAGES-1].nq;

   always_comb begin
      for (int k = 0; k < v3a_pkg::DIV_STAGES; k++) begin
         if (k == 0) begin
            src[k].nq  = dividend;
            src[k].rem = '0;
            src[k].den = divisor;
         end else begin
            src[k] = st_ff[k-1];
         end
         rem2[k] = {src[k].rem, src[k].nq[v3a_pkg::QW-1]};
         diff[k] = rem2[k] - {1'b0, src[k].den};
         st_in[k].den = src[k].den;
         if (rem2[k] >= {1'b0, src[k].den}) begin
            st_in[k].rem = diff[k][v3a_pkg::V-1:0];
            st_in[k].nq  = {src[k].nq[v3a_pkg::QW-2:0], 1'b1};
         end else begin
            st_in[k].rem = rem2[k][v3a_pkg::V-1:0];
            st_in[k].nq  = {src[k].nq[v3a_pkg::QW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      st_ff <= st_in;
   end

endmodule

`default_nettype wire

FILE: design/v3a_back.sv
// Back end: multiply, sum, saturate, square root, divide and result register.
`default_nettype none

module v3a_back (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     q_valid,
   input  wire v3a_pkg::word_type  q_word,
   output logic                    pop,
   output v3a_pkg::rsp_type        rsp_data,
   output logic                    rsp_strobe
);

   typedef struct packed {
      v3a_pkg::op_type                 op;
      logic [2:0][v3a_pkg::V-1:0]      a;
      logic [2:0][v3a_pkg::V-1:0]      b;
      logic [5:0][v3a_pkg::PW-1:0]     p;
   } st1_type;

   typedef struct packed {
      v3a_pkg::op_type                 op;
      logic [2:0][v3a_pkg::V-1:0]      a;
      logic [2:0][v3a_pkg::V-1:0]      b;
      logic [2:0][v3a_pkg::SW-1:0]     d;
   } st2_type;

   typedef struct packed {
      v3a_pkg::op_type                 op;
      logic [2:0][v3a_pkg::V-1:0]      a;
      logic [2:0][v3a_pkg::V-1:0]      b;
      logic [2:0][v3a_pkg::SW-1:0]     d;
      logic [v3a_pkg::SW-1:0]          tot;
   } st3_type;

   typedef struct packed {
      logic                            valid;
      v3a_pkg::op_type                 op;
      logic [2:0][v3a_pkg::V-1:0]      r;
      logic [v3a_pkg::V-1:0]           rs;
      logic                            sat;
      logic [2:0]                      a_neg;
      logic [2:0][v3a_pkg::V-1:0]      a_mag;
      logic [2:0]                      den_neg;
      logic [2:0][v3a_pkg::V-1:0]      den_mag;
      logic [2:0]                      den_zero;
      logic                            root_zero;
   } side_type;

   v3a_pkg::word_type  b0_ff;
   logic               b0_valid_ff;
   st1_type            b1_ff, b1_in;
   logic               b1_valid_ff;
   st2_type            b2_ff, b2_in;
   logic               b2_valid_ff;
   st3_type            b3_ff, b3_in;
   logic               b3_valid_ff;
   side_type           side_ff [v3a_pkg::SIDE_DEPTH];
   side_type           side_in [v3a_pkg::SIDE_DEPTH];
   v3a_pkg::rsp_type   out_ff, out_in;
   logic               strobe_ff;

   logic [5:0][v3a_pkg::V-1:0]       mx, my;
   logic signed [v3a_pkg::PW-1:0]    prod [6];
   logic signed [v3a_pkg::SW-1:0]    ai [3], bi [3], pe [3], po [3];
   logic [v3a_pkg::SW-1:0]           lmag [3];
   logic [v3a_pkg::SW-1:0]           tmag;
   logic                             lshift;
   v3a_pkg::fin_type [2:0]           lf;
   v3a_pkg::fin_type                 tf, mf;
   logic [v3a_pkg::V-1:0]            root;
   logic [2:0][v3a_pkg::QW-1:0]      dvd, quot;
   logic [2:0][v3a_pkg::V-1:0]       dvs;
   side_type                         sf;
   v3a_pkg::fin_type [2:0]           qf;
   logic [2:0]                       qneg;
   logic [2:0][v3a_pkg::V-1:0]       rv;
   logic [2:0]                       rsat;

   assign pop = q_valid;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         unique case (b0_ff.op)
            v3a_pkg::OP_CROSS: begin
               mx[2*i]   = b0_ff.a[(i + 1) % 3];
               my[2*i]   = b0_ff.b[(i + 2) % 3];
               mx[2*i+1] = b0_ff.a[(i + 2) % 3];
               my[2*i+1] = b0_ff.b[(i + 1) % 3];
            end
            v3a_pkg::OP_MAGSQ, v3a_pkg::OP_MAG, v3a_pkg::OP_UNIT: begin
               mx[2*i]   = b0_ff.a[i];
               my[2*i]   = b0_ff.a[i];
               mx[2*i+1] = '0;
               my[2*i+1] = '0;
            end
            default: begin
               mx[2*i]   = b0_ff.a[i];
               my[2*i]   = b0_ff.b[i];
               mx[2*i+1] = '0;
               my[2*i+1] = '0;
            end
         endcase
      end
      for (int k = 0; k < 6; k++) begin
         prod[k]    = $signed(mx[k]) * $signed(my[k]);
         b1_in.p[k] = prod[k];
      end
      b1_in.op = b0_ff.op;
      b1_in.a  = b0_ff.a;
      b1_in.b  = b0_ff.b;
   end

   always_comb begin
      b2_in.op = b1_ff.op;
      b2_in.a  = b1_ff.a;
      b2_in.b  = b1_ff.b;
      for (int i = 0; i < 3; i++) begin
         ai[i] = v3a_pkg::SW'($signed(b1_ff.a[i]));
         bi[i] = v3a_pkg::SW'($signed(b1_ff.b[i]));
         pe[i] = v3a_pkg::SW'($signed(b1_ff.p[2*i]));
         po[i] = v3a_pkg::SW'($signed(b1_ff.p[2*i+1]));
         unique case (b1_ff.op)
            v3a_pkg::OP_NEG: b2_in.d[i] = -ai[i];
            v3a_pkg::OP_ADD: b2_in.d[i] = ai[i] + bi[i];
            v3a_pkg::OP_SUB: b2_in.d[i] = ai[i] - bi[i];
            default:         b2_in.d[i] = pe[i] - po[i];
         endcase
      end
   end

   always_comb begin
      b3_in.op  = b2_ff.op;
      b3_in.a   = b2_ff.a;
      b3_in.b   = b2_ff.b;
      b3_in.d   = b2_ff.d;
      b3_in.tot = b2_ff.d[0] + b2_ff.d[1] + b2_ff.d[2];
   end

   v3a_sqrt u_sqrt (
      .clock (clock),
      .rad   (b3_ff.tot[v3a_pkg::PW-1:0]),
      .root  (root)
   );

   always_comb begin
      lshift = (b3_ff.op == v3a_pkg::OP_MUL) || (b3_ff.op == v3a_pkg::OP_CROSS);
      for (int i = 0; i < 3; i++) begin
         lmag[i] = b3_ff.d[i][v3a_pkg::SW-1] ? (~b3_ff.d[i] + 1'b1) : b3_ff.d[i];
         if (lshift) begin
            lmag[i] = lmag[i] >> v3a_pkg::F;
         end
         lf[i] = v3a_pkg::fin(v3a_pkg::MW'(lmag[i]), b3_ff.d[i][v3a_pkg::SW-1]);
      end
      tmag = b3_ff.tot[v3a_pkg::SW-1] ? (~b3_ff.tot + 1'b1) : b3_ff.tot;
      tf   = v3a_pkg::fin(v3a_pkg::MW'(tmag >> v3a_pkg::F), b3_ff.tot[v3a_pkg::SW-1]);

      side_in[0].valid     = b3_valid_ff;
      side_in[0].op        = b3_ff.op;
      side_in[0].r         = '0;
      side_in[0].rs        = '0;
      side_in[0].sat       = 1'b0;
      side_in[0].root_zero = 1'b0;
      for (int i = 0; i < 3; i++) begin
         side_in[0].a_neg[i]    = b3_ff.a[i][v3a_pkg::V-1];
         side_in[0].a_mag[i]    = b3_ff.a[i][v3a_pkg::V-1] ? (~b3_ff.a[i] + 1'b1) : b3_ff.a[i];
         side_in[0].den_neg[i]  = b3_ff.b[i][v3a_pkg::V-1];
         side_in[0].den_mag[i]  = b3_ff.b[i][v3a_pkg::V-1] ? (~b3_ff.b[i] + 1'b1) : b3_ff.b[i];
         side_in[0].den_zero[i] = b3_ff.b[i] == '0;
      end
      unique case (b3_ff.op)
         v3a_pkg::OP_NEG, v3a_pkg::OP_ADD, v3a_pkg::OP_SUB,
         v3a_pkg::OP_MUL, v3a_pkg::OP_CROSS: begin
            for (int i = 0; i < 3; i++) begin
               side_in[0].r[i] = lf[i].val;
            end
            side_in[0].sat = lf[0].sat | lf[1].sat | lf[2].sat;
         end
         v3a_pkg::OP_DOT, v3a_pkg::OP_MAGSQ: begin
            side_in[0].rs  = tf.val;
            side_in[0].sat = tf.sat;
         end
         default: ;
      endcase

      for (int k = 1; k < v3a_pkg::SIDE_DEPTH; k++) begin
         side_in[k] = side_ff[k-1];
      end
      mf = v3a_pkg::fin(v3a_pkg::MW'(root), 1'b0);
      side_in[v3a_pkg::SQRT_STAGES].root_zero = root == '0;
      if (side_ff[v3a_pkg::SQRT_STAGES-1].op == v3a_pkg::OP_MAG) begin
         side_in[v3a_pkg::SQRT_STAGES].rs  = mf.val;
         side_in[v3a_pkg::SQRT_STAGES].sat = mf.sat;
      end
      if (reset) begin
         for (int k = 0; k < v3a_pkg::SIDE_DEPTH; k++) begin
            side_in[k].valid = 1'b0;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dvd[i] = {side_ff[v3a_pkg::SQRT_STAGES-1].a_mag[i], {v3a_pkg::F{1'b0}}};
         dvs[i] = (side_ff[v3a_pkg::SQRT_STAGES-1].op == v3a_pkg::OP_UNIT) ?
                  root : side_ff[v3a_pkg::SQRT_STAGES-1].den_mag[i];
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_lane
      v3a_div u_div (
         .clock    (clock),
         .dividend (dvd[g]),
         .divisor  (dvs[g]),
         .quot     (quot[g])
      );
   end

   always_comb begin
      sf = side_ff[v3a_pkg::SIDE_DEPTH-1];
      for (int i = 0; i < 3; i++) begin
         qneg[i] = (sf.op == v3a_pkg::OP_UNIT) ? sf.a_neg[i] : (sf.a_neg[i] ^ sf.den_neg[i]);
         qf[i]   = v3a_pkg::fin(v3a_pkg::MW'(quot[i]), qneg[i]);
         rv[i]   = sf.r[i];
         rsat[i] = 1'b0;
         unique case (sf.op)
            v3a_pkg::OP_DIV: begin
               if (sf.den_zero[i]) begin
                  rv[i] = sf.a_neg[i] ? v3a_pkg::VMIN_V : v3a_pkg::VMAX_V;
               end else begin
                  rv[i]   = qf[i].val;
                  rsat[i] = qf[i].sat;
               end
            end
            v3a_pkg::OP_UNIT: begin
               if (sf.root_zero) begin
                  rv[i] = '0;
               end else begin
                  rv[i]   = qf[i].val;
                  rsat[i] = qf[i].sat;
               end
            end
            default: ;
         endcase
      end
      out_in.r_x       = v3a_pkg::IO_BITS'($signed(rv[0]));
      out_in.r_y       = v3a_pkg::IO_BITS'($signed(rv[1]));
      out_in.r_z       = v3a_pkg::IO_BITS'($signed(rv[2]));
      out_in.r_scalar  = v3a_pkg::IO_BITS'($signed(sf.rs));
      out_in.saturated = sf.sat | (|rsat);
      out_in.div_zero  = (sf.op == v3a_pkg::OP_DIV) && (|sf.den_zero);
   end

   always_ff @(posedge clock) begin
      b0_ff   <= q_word;
      b1_ff   <= b1_in;
      b2_ff   <= b2_in;
      b3_ff   <= b3_in;
      side_ff <= side_in;
      out_ff  <= out_in;
      if (reset) begin
         b0_valid_ff <= 1'b0;
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         b3_valid_ff <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         b0_valid_ff <= q_valid;
         b1_valid_ff <= b0_valid_ff;
         b2_valid_ff <= b1_valid_ff;
         b3_valid_ff <= b2_valid_ff;
         strobe_ff   <= side_ff[v3a_pkg::SIDE_DEPTH-1].valid;
      end
   end

   assign rsp_data   = out_ff;
   assign rsp_strobe = strobe_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      b0_valid_ff |-> ##(v3a_pkg::BACK_LAT) strobe_ff)
      else $error("word lost in back end");
   a_dz_scalar: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && out_ff.div_zero) |-> out_ff.r_scalar == '0)
      else $error("scalar result on a divide word");

endmodule

`default_nettype wire

FILE: design/vector3_alu.sv
// Top level of the three-component Q16.16 vector ALU.
//
//   channel  ports                         direction  handshake
//   request  start, busy, req_data         in         start && !busy
//   result   rsp_strobe, rsp_data          out        rsp_strobe, one cycle
//
// One word per cycle is accepted. At 32-bit words with 16 fraction bits, every accepted
// word passes through the queue, the b0 to b3 back-end registers, the 32-stage
// square root followed by the 48-stage divider, and the result register.
// Reset is synchronous, active high, and empties the queue and all valid bits.
// The back end drains the queue every cycle, so busy stays low in operation.
`default_nettype none

module vector3_alu (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     start,
   output logic                    busy,
   input  wire v3a_pkg::req_type   req_data,
   output v3a_pkg::rsp_type        rsp_data,
   output logic                    rsp_strobe
);

   logic               push, full, q_valid, pop;
   v3a_pkg::word_type  f_word, q_word;

   v3a_front u_front (
      .req_data (req_data),
      .start    (start),
      .full     (full),
      .push     (push),
      .word     (f_word),
      .busy     (busy)
   );

   v3a_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .word_in  (f_word),
      .pop      (pop),
      .valid    (q_valid),
      .full     (full),
      .word_out (q_word)
   );

   v3a_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_word     (q_word),
      .pop        (pop),
      .rsp_data   (rsp_data),
      .rsp_strobe (rsp_strobe)
   );

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking testbench for the three-component fixed-point vector ALU.
`timescale 1ns / 1ps
`default_nettype none

module testbench;

   localparam int MAX_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 120;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   v3a_pkg::req_type req_data = '0;
   v3a_pkg::rsp_type rsp_data;
   logic rsp_strobe;

   v3a_pkg::req_type pending_words[$];
   v3a_pkg::rsp_type expected_results[$];
   int mismatch_count = 0;
   int cycle_count = 0;
   int gap_left = 0;
   bit hold_for_drain = 1'b0;
   bit stimulus_done = 1'b0;

   vector3_alu uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_data(rsp_data), .rsp_strobe(rsp_strobe)
   );

   always #10 clock = ~clock;

   typedef struct {
      bit neg;
      logic [127:0] mag;
   } signmag_type;

   function automatic signmag_type to_signmag(longint v);
      signmag_type s;
      s.neg = v < 0;
      s.mag = v < 0 ? 128'(-v) : 128'(v);
      return s;
   endfunction

   function automatic signmag_type product(longint x, longint y);
      signmag_type p, q, s;
      p = to_signmag(x);
      q = to_signmag(y);
      s.neg = p.neg != q.neg;
      s.mag = p.mag * q.mag;
      return s;
   endfunction

   function automatic signmag_type sum(signmag_type x, signmag_type y);
      signmag_type s;
      if (x.neg == y.neg) begin
         s.neg = x.neg;
         s.mag = x.mag + y.mag;
      end else if (x.mag >= y.mag) begin
         s.neg = x.neg;
         s.mag = x.mag - y.mag;
      end else begin
         s.neg = y.neg;
         s.mag = y.mag - x.mag;
      end
      return s;
   endfunction

   function automatic signmag_type negated(signmag_type x);
      x.neg = !x.neg;
      return x;
   endfunction

   function automatic logic [31:0] clip(signmag_type x, int shift, ref bit sat);
      logic [127:0] m;
      m = x.mag >> shift;
      if (!x.neg || m == 0) begin
         if (m > 128'h7fffffff) begin
            sat = 1'b1;
            return 32'h7fffffff;
         end
         return m[31:0];
      end
      if (m > 128'h80000000) begin
         sat = 1'b1;
         return 32'h80000000;
      end
      return ~m[31:0] + 32'd1;
   endfunction

   function automatic logic [31:0] fixed_quotient(longint n, longint d, ref bit sat,
                                                 ref bit dz);
      signmag_type nn, dd, q;
      if (d == 0) begin
         dz = 1'b1;
         return n < 0 ? 32'h80000000 : 32'h7fffffff;
      end
      nn = to_signmag(n);
      dd = to_signmag(d);
      q.neg = nn.neg != dd.neg;
      q.mag = (nn.mag << v3a_pkg::FRAC_BITS) / dd.mag;
      return clip(q, 0, sat);
   endfunction

   function automatic logic [127:0] int_sqrt(logic [127:0] n);
      logic [127:0] res, b;
      res = 0;
      b = 128'd1 << 126;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic v3a_pkg::rsp_type alu_result(v3a_pkg::req_type w);
      v3a_pkg::rsp_type r;
      longint a[3], b[3], f;
      logic [31:0] v[3], sc;
      bit sat, dz;
      logic [127:0] sumsq, m;
      signmag_type s, t0, t1, t2;
      a[0] = longint'(w.a_x); a[1] = longint'(w.a_y); a[2] = longint'(w.a_z);
      b[0] = longint'(w.b_x); b[1] = longint'(w.b_y); b[2] = longint'(w.b_z);
      f = longint'(w.factor);
      v = '{0, 0, 0};
      sc = 0;
      sat = 0;
      dz = 0;
      t0 = product(a[0], a[0]);
      t1 = product(a[1], a[1]);
      t2 = product(a[2], a[2]);
      sumsq = t0.mag + t1.mag + t2.mag;
      case (w.mode)
         v3a_pkg::MODE_NEG:
            for (int i = 0; i < 3; i++) v[i] = clip(to_signmag(-a[i]), 0, sat);
         v3a_pkg::MODE_ADD:
            for (int i = 0; i < 3; i++) v[i] = clip(to_signmag(a[i] + b[i]), 0, sat);
         v3a_pkg::MODE_SUB:
            for (int i = 0; i < 3; i++) v[i] = clip(to_signmag(a[i] - b[i]), 0, sat);
         v3a_pkg::MODE_MUL:
            for (int i = 0; i < 3; i++)
               v[i] = clip(product(a[i], b[i]), v3a_pkg::FRAC_BITS, sat);
         v3a_pkg::MODE_SCALE:
            for (int i = 0; i < 3; i++)
               v[i] = clip(product(a[i], f), v3a_pkg::FRAC_BITS, sat);
         v3a_pkg::MODE_DIV:
            for (int i = 0; i < 3; i++) v[i] = fixed_quotient(a[i], b[i], sat, dz);
         v3a_pkg::MODE_DIVSCALAR:
            for (int i = 0; i < 3; i++) v[i] = fixed_quotient(a[i], f, sat, dz);
         v3a_pkg::MODE_DOT:
            sc = clip(sum(sum(product(a[0], b[0]), product(a[1], b[1])),
                          product(a[2], b[2])), v3a_pkg::FRAC_BITS, sat);
         v3a_pkg::MODE_CROSS: begin
            v[0] = clip(sum(product(a[1], b[2]), negated(product(a[2], b[1]))),
                        v3a_pkg::FRAC_BITS, sat);
            v[1] = clip(sum(product(a[2], b[0]), negated(product(a[0], b[2]))),
                        v3a_pkg::FRAC_BITS, sat);
            v[2] = clip(sum(product(a[0], b[1]), negated(product(a[1], b[0]))),
                        v3a_pkg::FRAC_BITS, sat);
         end
         v3a_pkg::MODE_MAGSQ: begin
            s.neg = 0;
            s.mag = sumsq;
            sc = clip(s, v3a_pkg::FRAC_BITS, sat);
         end
         v3a_pkg::MODE_MAG: begin
            s.neg = 0;
            s.mag = int_sqrt(sumsq);
            sc = clip(s, 0, sat);
         end
         v3a_pkg::MODE_UNIT: begin
            m = int_sqrt(sumsq);
            if (m != 0)
               for (int i = 0; i < 3; i++) begin
                  s = to_signmag(a[i]);
                  s.mag = (s.mag << v3a_pkg::FRAC_BITS) / m;
                  v[i] = clip(s, 0, sat);
               end
         end
         default: ;
      endcase
      r.r_x = v[0];
      r.r_y = v[1];
      r.r_z = v[2];
      r.r_scalar = sc;
      r.saturated = sat;
      r.div_zero = dz;
      return r;
   endfunction

   function automatic logic [31:0] random_component();
      case ($urandom_range(0, 9))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'h0;
         3: return 32'($signed($urandom_range(0, 8)) - 4) << 16;
         4, 5: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
         6: return 32'($signed($urandom_range(0, 512)) - 256);
         default: return $urandom;
      endcase
   endfunction

   function automatic v3a_pkg::req_type random_word();
      v3a_pkg::req_type w;
      w.mode = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                            : 4'($urandom_range(0, 11));
      w.a_x = random_component(); w.a_y = random_component(); w.a_z = random_component();
      w.b_x = random_component(); w.b_y = random_component(); w.b_z = random_component();
      w.factor = random_component();
      return w;
   endfunction

   function automatic int random_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   initial begin
      v3a_pkg::req_type w;
      logic [31:0] edge_vals[4];
      edge_vals = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h00010000};
      for (int m = 0; m < 16; m++) begin
         w.mode = 4'(m);
         w.a_x = edge_vals[m % 4]; w.a_y = 32'hffff0000; w.a_z = edge_vals[(m + 1) % 4];
         w.b_x = edge_vals[(m + 2) % 4]; w.b_y = 32'h00020000; w.b_z = 32'h0;
         w.factor = (m % 2) ? 32'h0 : 32'h80000000;
         pending_words.push_back(w);
      end
      w = '0;
      w.mode = v3a_pkg::MODE_UNIT;
      pending_words.push_back(w);
      w.mode = v3a_pkg::MODE_DIV;
      w.a_x = 32'h80000000; w.a_y = 32'h0; w.a_z = 32'h00050000;
      pending_words.push_back(w);
      w.mode = v3a_pkg::MODE_MAGSQ;
      w.a_x = 32'h80000000; w.a_y = 32'h80000000; w.a_z = 32'h80000000;
      pending_words.push_back(w);
      w.mode = v3a_pkg::MODE_MAG;
      pending_words.push_back(w);
      w.mode = v3a_pkg::MODE_DOT;
      w.b_x = 32'h80000000; w.b_y = 32'h80000000; w.b_z = 32'h80000000;
      pending_words.push_back(w);
      w.mode = v3a_pkg::MODE_CROSS;
      w.b_x = 32'h7fffffff; w.b_y = 32'h80000000; w.b_z = 32'h7fffffff;
      pending_words.push_back(w);
      for (int i = 0; i < 1900; i++) pending_words.push_back(random_word());
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == 5) reset <= 1'b0;
      if (!reset) begin
         if (start && !busy) expected_results.push_back(alu_result(req_data));
         if (start && busy) begin
            start <= 1'b1;
         end else if (gap_left > 0) begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (hold_for_drain && (expected_results.size() != 0 || start)) begin
            start <= 1'b0;
         end else if (pending_words.size() == 0) begin
            start <= 1'b0;
            stimulus_done <= 1'b1;
         end else begin
            if (pending_words.size() == 1000) hold_for_drain <= 1'b1;
            else hold_for_drain <= 1'b0;
            start <= 1'b1;
            req_data <= pending_words.pop_front();
            if (cycle_count % 200 < 150) gap_left <= random_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_results.size() == 0) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10) $display("unexpected result %p", rsp_data);
         end else if (rsp_data !== expected_results[0]) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
               $display("mismatch: expected %p actual %p", expected_results[0], rsp_data);
            void'(expected_results.pop_front());
         end else begin
            void'(expected_results.pop_front());
         end
      end
   end

   initial begin
      wait (stimulus_done && expected_results.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("vector3_alu verification clean");
      else
         $display("vector3_alu verification failed");
      $finish;
   end

   initial begin
      wait (cycle_count >= MAX_CYCLES);
      $display("vector3_alu verification failed");
      $finish;
   end

endmodule

`default_nettype wire

FILE: filelist.f
design/v3a_pkg.sv
design/v3a_front.sv
design/v3a_queue.sv
design/v3a_sqrt.sv
design/v3a_div.sv
design/v3a_back.sv
design/vector3_alu.sv
bench/testbench.sv
